[src/dispc_pkg.sv]
`default_nettype none

package dispc_pkg;

  // Item operations
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_HOLD  = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_COUNT_DOWN  = 2'd0;
  localparam logic [1:0] CFG_TIME_FORMAT = 2'd1;
  localparam logic [1:0] CFG_POINT_MASK  = 2'd2;

  localparam logic [3:0] POINT_MASK_RESET = 4'h8;
  // In time mode only the minutes-units digit shows its point
  localparam logic [3:0] TIME_POINTS      = 4'b0010;

  typedef logic [3:0] digit_t;
  typedef logic [7:0] seg_t;

  typedef struct packed {
    digit_t thou;
    digit_t hund;
    digit_t tens;
    digit_t units;
  } bcd4_t;

  typedef struct packed {
    seg_t thou;
    seg_t hund;
    seg_t tens;
    seg_t units;
  } seg4_t;

  typedef struct packed {
    logic       count_down;
    logic       time_format;
    logic [3:0] point_mask;
  } cfg_t;

  // Item held in the input register: load value already split off its thousands
  typedef struct packed {
    op_t        op;
    digit_t     thou;
    logic [9:0] rem;
  } item_t;

  typedef struct packed {
    bcd4_t digits;
    seg4_t segs;
  } result_t;

  localparam bcd4_t BCD_ZERO = '{thou: 4'd0, hund: 4'd0, tens: 4'd0, units: 4'd0};
  localparam bcd4_t BCD_NINES = '{thou: 4'd9, hund: 4'd9, tens: 4'd9, units: 4'd9};

  // Seven-segment pattern, a in bit 0 through g in bit 6; blank for non-digits
  function automatic logic [6:0] seg7(input digit_t d);
    logic [6:0] s;
    case (d)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // Quotients by threshold compare; the compares are independent
  function automatic logic [4:0] thou_quot(input logic [13:0] v);
    logic [4:0] q;
    q = '0;
    for (int k = 1; k <= 16; k++) begin
      if (v >= 14'(k * 1000)) q = 5'(k);
    end
    return q;
  endfunction

  function automatic digit_t hund_quot(input logic [9:0] v);
    digit_t q;
    q = '0;
    for (int k = 1; k <= 9; k++) begin
      if (v >= 10'(k * 100)) q = 4'(k);
    end
    return q;
  endfunction

  function automatic digit_t tens_quot(input logic [6:0] v);
    digit_t q;
    q = '0;
    for (int k = 1; k <= 9; k++) begin
      if (v >= 7'(k * 10)) q = 4'(k);
    end
    return q;
  endfunction

endpackage

`default_nettype wire

[src/dispc_ld_split.sv]
`default_nettype none

module dispc_ld_split
  import dispc_pkg::*;
(
  input  wire logic [13:0] load_value,
  output digit_t           thou,
  output logic [9:0]       rem
);

  logic [4:0]  quot;
  logic [13:0] base;

  // Thousands quotient (0..16), kept mod 10; remainder below 1000
  assign quot = thou_quot(load_value);
  assign base = 14'(quot) * 14'd1000;
  assign thou = (quot >= 5'd10) ? 4'(quot - 5'd10) : quot[3:0];
  assign rem  = 10'(load_value - base);

endmodule

`default_nettype wire

[src/dispc_core.sv]
`default_nettype none

module dispc_core
  import dispc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    step_en,
  input  wire item_t   item,
  input  wire cfg_t    cfg,
  output result_t      result
);

  bcd4_t      up_r, up_nxt, up_aft;
  bcd4_t      down_r, down_nxt, down_aft;
  logic       primed_r, primed_nxt, primed_aft;
  bcd4_t      ld_digits;
  digit_t     ld_hund, ld_tens;
  logic [6:0] ld_r2;
  bcd4_t      shown;
  logic [3:0] pts;

  // Up step; minutes:seconds clamps seconds to 59 first so the carry is kept
  function automatic bcd4_t step_up(input bcd4_t d, input logic tm);
    logic [4:0] th, h, t, u, lim;
    bcd4_t r;
    th  = {1'b0, d.thou};
    h   = {1'b0, d.hund};
    t   = {1'b0, d.tens};
    u   = {1'b0, d.units};
    lim = tm ? 5'd6 : 5'd10;
    if (tm && t >= 5'd6) begin
      t = 5'd5;
      u = 5'd9;
    end
    u = u + 5'd1;
    if (u >= 5'd10) begin
      u = 5'd0;
      t = t + 5'd1;
    end
    if (t >= lim) begin
      t = 5'd0;
      h = h + 5'd1;
    end
    if (h >= 5'd10) begin
      h = 5'd0;
      th = th + 5'd1;
    end
    if (th >= 5'd10) begin
      th = 5'd0;
      h  = 5'd0;
      t  = 5'd0;
      u  = 5'd0;
    end
    r.thou  = th[3:0];
    r.hund  = h[3:0];
    r.tens  = t[3:0];
    r.units = u[3:0];
    return r;
  endfunction

  // Down step with borrow chain; floors at zero
  function automatic bcd4_t step_down(input bcd4_t d, input logic tm);
    logic [4:0] th, h, t, u;
    bcd4_t r;
    th = {1'b0, d.thou};
    h  = {1'b0, d.hund};
    t  = {1'b0, d.tens};
    u  = {1'b0, d.units};
    if (tm && t >= 5'd6) begin
      t = 5'd5;
      u = 5'd10;
    end
    if (u != 5'd0) begin
      u = u - 5'd1;
    end else begin
      u = 5'd9;
      if (t != 5'd0) begin
        t = t - 5'd1;
      end else begin
        t = tm ? 5'd5 : 5'd9;
        if (h != 5'd0) begin
          h = h - 5'd1;
        end else begin
          h = 5'd9;
          if (th != 5'd0) begin
            th = th - 5'd1;
          end else begin
            th = 5'd0;
            h  = 5'd0;
            t  = 5'd0;
            u  = 5'd0;
          end
        end
      end
    end
    r.thou  = th[3:0];
    r.hund  = h[3:0];
    r.tens  = t[3:0];
    r.units = u[3:0];
    return r;
  endfunction

  // Remaining load digits from the sub-thousand remainder
  always_comb begin
    ld_hund         = hund_quot(item.rem);
    ld_r2           = 7'(item.rem - 10'(ld_hund) * 10'd100);
    ld_tens         = tens_quot(ld_r2);
    ld_digits.thou  = item.thou;
    ld_digits.hund  = ld_hund;
    ld_digits.tens  = ld_tens;
    ld_digits.units = 4'(ld_r2 - 7'(ld_tens) * 7'd10);
  end

  // Counter state after applying the op
  always_comb begin
    up_aft     = up_r;
    down_aft   = down_r;
    primed_aft = primed_r;
    case (item.op)
      OP_TICK: begin
        if (cfg.count_down) begin
          down_aft = step_down(down_r, cfg.time_format);
        end else if (primed_r) begin
          primed_aft = 1'b0;
        end else begin
          up_aft = step_up(up_r, cfg.time_format);
        end
      end
      OP_LOAD: begin
        down_aft = ld_digits;
      end
      OP_CLEAR: begin
        up_aft     = BCD_ZERO;
        down_aft   = BCD_ZERO;
        primed_aft = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign up_nxt     = step_en ? up_aft : up_r;
  assign down_nxt   = step_en ? down_aft : down_r;
  assign primed_nxt = step_en ? primed_aft : primed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r     <= BCD_ZERO;
      down_r   <= BCD_NINES;
      primed_r <= 1'b1;
    end else begin
      up_r     <= up_nxt;
      down_r   <= down_nxt;
      primed_r <= primed_nxt;
    end
  end

  // Display: selected counter, segments and decimal points
  assign shown = cfg.count_down ? down_aft : up_aft;
  assign pts   = cfg.time_format ? TIME_POINTS : cfg.point_mask;

  always_comb begin
    result.digits     = shown;
    result.segs.thou  = {pts[0], seg7(shown.thou)};
    result.segs.hund  = {pts[1], seg7(shown.hund)};
    result.segs.tens  = {pts[2], seg7(shown.tens)};
    result.segs.units = {pts[3], seg7(shown.units)};
  end

endmodule

`default_nettype wire

[src/bcd_display_counter_with_segments.sv]
// Four-digit BCD up/down counter with seven-segment outputs.
//
// Input channel (in_valid / in_stall): each transfer carries an op (tick,
// load down counter, clear both, or a no-op) and a decimal load value.
// Result channel (out_valid / out_stall): one result per input item, giving
// the four digits of the shown counter and their segment bytes
// (a..g in bits 0..6, decimal point in bit 7).
// Config channel (cfg_valid / cfg_ready): index 0 count_down, 1 time_format,
// 2 point_mask; cfg_ready is always high. Write only while idle.
//
// From an input transfer to the result: one input register, then the digit
// carry chain and segment decode into the result register. Throughput is one
// item per cycle while no stalled result holds the registers; the counter state
// updates as an item leaves the input register, so the next item sees it.
// A stalled result holds; the input register still takes one more item, and
// in_stall rises only when both registers are full.
// Reset: up counter 0000 (first up tick shows 0000), down counter 9999,
// count up, decimal mode, point on the units digit; both registers empty.
`default_nettype none

module bcd_display_counter_with_segments
  import dispc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [13:0] in_load_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_digit_thousands,
  output logic [3:0]       out_digit_hundreds,
  output logic [3:0]       out_digit_tens,
  output logic [3:0]       out_digit_units,
  output logic [7:0]       out_segs_thousands,
  output logic [7:0]       out_segs_hundreds,
  output logic [7:0]       out_segs_tens,
  output logic [7:0]       out_segs_units,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);

  cfg_t       cfg_r, cfg_nxt;
  logic       s1_valid_r, s1_valid_nxt;
  item_t      s1_item_r, s1_item_nxt;
  logic       out_valid_r, out_valid_nxt;
  result_t    res_r, res_nxt;
  result_t    core_res;
  digit_t     split_thou;
  logic [9:0] split_rem;
  logic       advance;
  logic       in_xfer;
  logic       step_en;

  // Config writes
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_COUNT_DOWN:  cfg_nxt.count_down  = cfg_data[0];
        CFG_TIME_FORMAT: cfg_nxt.time_format = cfg_data[0];
        CFG_POINT_MASK:  cfg_nxt.point_mask  = cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Handshake: result register drains or is empty, input register moves on
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;
  assign step_en  = s1_valid_r && advance;

  dispc_ld_split u_ld_split (
    .load_value (in_load_value),
    .thou       (split_thou),
    .rem        (split_rem)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_item_nxt  = s1_item_r;
    if (in_xfer) begin
      s1_valid_nxt     = 1'b1;
      s1_item_nxt.op   = op_t'(in_op);
      s1_item_nxt.thou = split_thou;
      s1_item_nxt.rem  = split_rem;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  dispc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (s1_item_r),
    .cfg     (cfg_r),
    .result  (core_res)
  );

  // Result register
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;
  assign res_nxt       = step_en ? core_res : res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.count_down  <= 1'b0;
      cfg_r.time_format <= 1'b0;
      cfg_r.point_mask  <= POINT_MASK_RESET;
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
    res_r     <= res_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_digit_thousands = res_r.digits.thou;
  assign out_digit_hundreds  = res_r.digits.hund;
  assign out_digit_tens      = res_r.digits.tens;
  assign out_digit_units     = res_r.digits.units;
  assign out_segs_thousands  = res_r.segs.thou;
  assign out_segs_hundreds   = res_r.segs.hund;
  assign out_segs_tens       = res_r.segs.tens;
  assign out_segs_units      = res_r.segs.units;

endmodule

`default_nettype wire
